>>> design/bspcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the helper function of the bit-serial prefix code decoder.
// No dependencies; every other file of the block imports this package.
package bspcd_pkg;

   localparam int MAX_LEN     = 12;
   localparam int WORD_BITS   = 64;
   localparam int SYM_W       = 8;
   localparam int TABLE_DEPTH = 2 << MAX_LEN;
   localparam int IDX_W       = MAX_LEN + 1;
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int CNT_W       = $clog2(WORD_BITS + 1);

   typedef enum logic [1:0] {
      MODE_DECODE      = 2'd0,
      MODE_LOAD        = 2'd1,
      MODE_CLEAR_CODE  = 2'd2,
      MODE_CLEAR_TABLE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic             present;
      logic [SYM_W-1:0] symbol;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } table_wr_type;

   // Index of the code obtained by appending one bit to a partial code.
   function automatic logic [IDX_W-1:0] append_index(input logic [MAX_LEN-1:0] code,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic bit_in);
      logic [MAX_LEN:0]   wide;
      logic [LEN_W-1:0]   ext_len;
      wide    = {code, bit_in};
      ext_len = len + LEN_W'(1);
      return (IDX_W'(1) << ext_len) | IDX_W'(wide[MAX_LEN-1:0]);
   endfunction

endpackage

>>> design/bspcd_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the prefix code decoder.
// Depends on bspcd_pkg for field widths.
interface bspcd_req_if
   import bspcd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [63:0]       data_word;
   logic [6:0]        valid_bits;
   logic [3:0]        entry_length;
   logic [11:0]       entry_code;
   logic [SYM_W-1:0]  entry_symbol;
   logic              entry_present;

   modport source (output valid, mode, data_word, valid_bits, entry_length, entry_code,
                   entry_symbol, entry_present, input ready);
   modport sink   (input valid, mode, data_word, valid_bits, entry_length, entry_code,
                   entry_symbol, entry_present, output ready);
endinterface

interface bspcd_rsp_if
   import bspcd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [SYM_W-1:0]  symbol;
   logic              code_error;
   logic              last;

   modport source (output valid, symbol, code_error, last, input ready);
   modport sink   (input valid, symbol, code_error, last, output ready);
endinterface

>>> design/bit_serial_prefix_code_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the bit-serial prefix code decoder.
// Depends on bspcd_pkg, bspcd_if and bspcd_table.

// Decodes prefix-coded words one bit per cycle while the response side does not stall. A
// decode word with n valid bits (n clamped to 64) is accepted, decoded one bit at a time
// and closed by releasing its final result. The bit rate is set by the loop through the code
// table memory: each bit needs one registered table read, and the address of the next read
// depends on whether this bit ended a code. A table write or a partial code clear is done
// as its request is accepted. A table clear, and the pass that follows reset, sweep the
// 8192-entry table one entry a cycle, so req_chan.ready stays low until the sweep ends.
// Each result word carries the symbol, an error flag (symbol 0) when a code runs to
// 12 bits without a match, and last on the final result caused by the word; the newest
// result is held back until the next one or the end of the word shows whether it is last.
module bit_serial_prefix_code_decoder_core
   import bspcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bspcd_req_if.sink   req_chan,
   bspcd_rsp_if.source rsp_chan
);

   state_type          state_ff, state_in;
   logic [WORD_BITS-1:0] word_ff, word_in;     // bit shift register, current bit on top
   logic [CNT_W-1:0]   left_ff, left_in;       // bits still to decode, current included
   logic [MAX_LEN-1:0] code_ff, code_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;       // address of the lookup in flight
   logic               hold_valid_ff, hold_valid_in;
   logic [SYM_W-1:0]   hold_sym_ff, hold_sym_in;
   logic               hold_err_ff, hold_err_in;
   logic               out_valid_ff, out_valid_in;
   logic [SYM_W-1:0]   out_sym_ff, out_sym_in;
   logic               out_err_ff, out_err_in;
   logic               out_last_ff, out_last_in;

   table_wr_type       tbl_wr;
   logic               tbl_clear;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          entry;
   logic               tbl_busy;

   logic               req_ready;
   logic               can_emit;
   logic               push;
   logic [SYM_W-1:0]   push_sym;
   logic               push_err;
   logic               push_last;
   logic [CNT_W-1:0]   nbits;
   logic [IDX_W-1:0]   first_idx;
   logic [IDX_W-1:0]   load_bit;
   logic [IDX_W-1:0]   load_idx;
   logic               load_ok;
   logic [MAX_LEN:0]   ext_wide;
   logic [MAX_LEN-1:0] ext_code;
   logic [LEN_W-1:0]   ext_len;
   logic               hit;
   logic               over;
   logic               go;

   bspcd_table u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .clear_req (tbl_clear),
      .rd_addr   (rd_addr),
      .rd_data   (entry),
      .busy      (tbl_busy)
   );

   always_comb begin
      req_ready = (state_ff == ST_IDLE) && !tbl_busy;
      can_emit  = !out_valid_ff || rsp_chan.ready;

      // clamp the bit count to the word width
      nbits = (32'(req_chan.valid_bits) > WORD_BITS) ? CNT_W'(WORD_BITS)
                                                      : CNT_W'(req_chan.valid_bits);
      first_idx = append_index(code_ff, len_ff, req_chan.data_word[WORD_BITS-1]);

      // table write: drop code bits above the entry length
      load_ok  = (req_chan.entry_length != '0) && (32'(req_chan.entry_length) <= MAX_LEN);
      load_bit = IDX_W'(1) << req_chan.entry_length;
      load_idx = load_bit | (IDX_W'(req_chan.entry_code) & (load_bit - IDX_W'(1)));

      // the current bit extends the partial code
      ext_wide = {code_ff, word_ff[WORD_BITS-1]};
      ext_code = ext_wide[MAX_LEN-1:0];
      ext_len  = len_ff + LEN_W'(1);
      hit      = entry.present;
      over     = !hit && (32'(ext_len) >= MAX_LEN);
      go       = !hold_valid_ff || can_emit;

      state_in      = state_ff;
      word_in       = word_ff;
      left_in       = left_ff;
      code_in       = code_ff;
      len_in        = len_ff;
      addr_in       = addr_ff;
      hold_valid_in = hold_valid_ff;
      hold_sym_in   = hold_sym_ff;
      hold_err_in   = hold_err_ff;
      out_valid_in  = out_valid_ff;
      out_sym_in    = out_sym_ff;
      out_err_in    = out_err_ff;
      out_last_in   = out_last_ff;
      rd_addr       = addr_ff;
      tbl_wr        = '0;
      tbl_clear     = 1'b0;
      push          = 1'b0;
      push_sym      = hold_sym_ff;
      push_err      = hold_err_ff;
      push_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid && req_ready) begin
               unique case (mode_type'(req_chan.mode))
                  MODE_DECODE: begin
                     if (nbits != '0) begin
                        word_in  = req_chan.data_word[WORD_BITS-1:0];
                        left_in  = nbits;
                        addr_in  = first_idx;
                        rd_addr  = first_idx;
                        state_in = ST_DECODE;
                     end
                  end
                  MODE_LOAD: begin
                     tbl_wr.en           = load_ok;
                     tbl_wr.addr         = load_idx;
                     tbl_wr.data.present = req_chan.entry_present;
                     tbl_wr.data.symbol  = req_chan.entry_present ? req_chan.entry_symbol
                                                                  : '0;
                  end
                  MODE_CLEAR_CODE: begin
                     code_in = '0;
                     len_in  = '0;
                  end
                  MODE_CLEAR_TABLE: begin
                     tbl_clear = 1'b1;
                  end
               endcase
            end
         end
         ST_DECODE: begin
            // hold the lookup while an older result cannot move out
            if (go) begin
               if (hit || over) begin
                  code_in       = '0;
                  len_in        = '0;
                  push          = hold_valid_ff;
                  hold_valid_in = 1'b1;
                  hold_sym_in   = hit ? entry.symbol : '0;
                  hold_err_in   = !hit;
               end else begin
                  code_in = ext_code;
                  len_in  = ext_len;
               end
               word_in = word_ff << 1;
               left_in = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  addr_in = append_index(code_in, len_in, word_ff[WORD_BITS-2]);
                  rd_addr = addr_in;
               end
            end
         end
         ST_FLUSH: begin
            // release the held result as the last of the word
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (can_emit) begin
               push          = 1'b1;
               push_last     = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push) begin
         out_valid_in = 1'b1;
         out_sym_in   = push_sym;
         out_err_in   = push_err;
         out_last_in  = push_last;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         code_ff       <= '0;
         len_ff        <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         code_ff       <= code_in;
         len_ff        <= len_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      left_ff     <= left_in;
      addr_ff     <= addr_in;
      hold_sym_ff <= hold_sym_in;
      hold_err_ff <= hold_err_in;
      out_sym_ff  <= out_sym_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.symbol     = out_sym_ff;
   assign rsp_chan.code_error = out_err_ff;
   assign rsp_chan.last       = out_last_ff;

endmodule

>>> design/bspcd_table.sv
`timescale 1ns / 1ps
// Code table memory with registered read and a clearing sweep after reset or on request.
// Depends on bspcd_pkg.
module bspcd_table
   import bspcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  table_wr_type     wr,
   input  logic             clear_req,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   output logic             busy
);

   entry_type        mem [TABLE_DEPTH];
   entry_type        rd_data_ff;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             we;
   logic [IDX_W-1:0] waddr;
   entry_type        wdata;

   always_comb begin
      busy_in  = busy_ff;
      sweep_in = sweep_ff;
      if (clear_req) begin
         busy_in  = 1'b1;
         sweep_in = '0;
      end else if (busy_ff) begin
         sweep_in = sweep_ff + IDX_W'(1);
         if (sweep_ff == IDX_W'(TABLE_DEPTH - 1)) busy_in = 1'b0;
      end
      // sweep owns the write port while it runs
      we    = busy_ff | wr.en;
      waddr = busy_ff ? sweep_ff : wr.addr;
      wdata = busy_ff ? '0 : wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         sweep_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

>>> design/bspcd_checker.sv
`timescale 1ns / 1ps
// Port-level assertions of the prefix code decoder and the bind that attaches them.
// Depends on bspcd_pkg and bit_serial_prefix_code_decoder_core.
module bspcd_checker
   import bspcd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [1:0]       req_mode,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [SYM_W-1:0] rsp_symbol,
   input logic             rsp_code_error,
   input logic             rsp_last
);

   // table sweep starts at reset
   a_reset_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request side ready right after reset");

   // a table clear blocks requests while it sweeps
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_mode == MODE_CLEAR_TABLE)) |=> !req_ready)
      else $error("request accepted during table clear");

   // when idle, only a word's final result may still be waiting
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) |-> rsp_last)
      else $error("non-final result pending while idle");

   // error results carry symbol zero
   a_err_sym: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_code_error) |-> (rsp_symbol == '0))
      else $error("error result with non-zero symbol");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_symbol)
                                     && $stable(rsp_code_error) && $stable(rsp_last)))
      else $error("stalled response word changed");

endmodule

bind bit_serial_prefix_code_decoder_core bspcd_checker u_bspcd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_mode       (req_chan.mode),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_symbol     (rsp_chan.symbol),
   .rsp_code_error (rsp_chan.code_error),
   .rsp_last       (rsp_chan.last)
);
